### rtl/core/dsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types, codes and the CRC-8 step for the temperature readout sequencer.
// ----------------------------------------------------------------------------
package dsr_pkg;

    // Event kinds on the input stream
    localparam logic [1:0] CMD_ROM     = 2'd0;
    localparam logic [1:0] CMD_POLL    = 2'd1;
    localparam logic [1:0] CMD_SCRATCH = 2'd2;
    localparam logic [1:0] CMD_TICK    = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_CONV_STARTED = 3'd0;
    localparam logic [2:0] ST_ROM_CRC_BAD  = 3'd1;
    localparam logic [2:0] ST_UNKNOWN_FAM  = 3'd2;
    localparam logic [2:0] ST_TIMEOUT      = 3'd3;
    localparam logic [2:0] ST_TEMP_READY   = 3'd4;

    // Sequencer phases (code 3 is unreachable and acts as the ROM phase)
    localparam logic [1:0] PH_ROM     = 2'd0;
    localparam logic [1:0] PH_WAIT    = 2'd1;
    localparam logic [1:0] PH_SCRATCH = 2'd2;

    // Family codes
    localparam logic [7:0] FAM_S_PART  = 8'h10;
    localparam logic [7:0] FAM_B_PART  = 8'h28;
    localparam logic [7:0] FAM_B2_PART = 8'h22;

    localparam int          ROM_LEN       = 8;
    localparam int          SCRATCH_LEN   = 9;
    localparam int          CNT_W         = 4;
    localparam int          ELAPSED_W     = 17;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [CNT_W-1:0] ROM_LAST     = CNT_W'(ROM_LEN - 1);
    localparam logic [CNT_W-1:0] SCRATCH_LAST = CNT_W'(SCRATCH_LEN - 1);

    // Count-remain constant for S parts
    localparam logic [15:0] COUNT_PER_C = 16'd12;
    localparam logic [7:0]  CR_FULL     = 8'h10;
    localparam logic [15:0] INT_MASK    = 16'hFFF0;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } event_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [15:0] temperature;
        logic               sensor_is_s;
        logic               scratch_crc_ok;
    } result_t;

    // Scratchpad bytes that feed the temperature conversion
    typedef struct packed {
        logic [7:0] temp_lsb;
        logic [7:0] temp_msb;
        logic [7:0] config_byte;
        logic [7:0] count_remain;
        logic [7:0] count_per_c;
        logic       is_s;
    } temp_src_t;

    // One byte of the Dallas CRC-8 (reflected polynomial 0x8C)
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/core/dsr_temp_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_temp_calc
// Scratchpad bytes to signed Q12.4 Celsius: count-remain or plain scaling (S), resolution mask (B).
// ----------------------------------------------------------------------------
module dsr_temp_calc (
    input  dsr_pkg::temp_src_t src,
    output logic signed [15:0] temperature
);

    logic [15:0] raw;
    logic [15:0] raw_s;
    logic [15:0] b_val;

    assign raw   = {src.temp_msb, src.temp_lsb};
    assign raw_s = raw << 3;

    always_comb begin
        case (src.config_byte[6:5])
            2'b00:   b_val = raw & ~16'h0007;
            2'b01:   b_val = raw & ~16'h0003;
            2'b10:   b_val = raw & ~16'h0001;
            default: b_val = raw;
        endcase
    end

    always_comb begin
        if (src.is_s) begin
            if (src.count_per_c == dsr_pkg::CR_FULL) begin
                temperature = (raw_s & dsr_pkg::INT_MASK) + dsr_pkg::COUNT_PER_C
                              - {8'h00, src.count_remain};
            end else begin
                temperature = raw_s;
            end
        end else begin
            temperature = b_val;
        end
    end

endmodule

### rtl/core/dsr_seq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_seq_core
// Phase state, CRC, tick counter and scratchpad bytes; one event per advance.
// ----------------------------------------------------------------------------
module dsr_seq_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  dsr_pkg::event_t     evt,
    input  logic [15:0]         timeout_ms,
    output logic                res_valid,
    output dsr_pkg::result_t    res
);

    logic [1:0]                     phase_reg, phase_next;
    logic [dsr_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [7:0]                     crc_reg, crc_next;
    logic                           fam_s_reg, fam_s_next;
    logic [dsr_pkg::ELAPSED_W-1:0]  elapsed_reg, elapsed_next;

    // Only the scratchpad bytes the conversion reads are kept
    logic [7:0] sp0_reg, sp0_next;
    logic [7:0] sp1_reg, sp1_next;
    logic [7:0] sp4_reg, sp4_next;
    logic [7:0] sp6_reg, sp6_next;
    logic [7:0] sp7_reg, sp7_next;

    logic [dsr_pkg::CNT_W-1:0] cnt;
    logic [7:0]                crc_step;
    logic signed [15:0]        temp_val;
    dsr_pkg::temp_src_t        tsrc;

    assign crc_step = dsr_pkg::crc8_step(crc_reg, evt.data_byte);

    assign tsrc.temp_lsb     = sp0_reg;
    assign tsrc.temp_msb     = sp1_reg;
    assign tsrc.config_byte  = sp4_reg;
    assign tsrc.count_remain = sp6_reg;
    assign tsrc.count_per_c  = sp7_reg;
    assign tsrc.is_s         = fam_s_reg;

    dsr_temp_calc u_temp (
        .src         (tsrc),
        .temperature (temp_val)
    );

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        fam_s_next   = fam_s_reg;
        elapsed_next = elapsed_reg;
        sp0_next     = sp0_reg;
        sp1_next     = sp1_reg;
        sp4_next     = sp4_reg;
        sp6_next     = sp6_reg;
        sp7_next     = sp7_reg;
        cnt          = count_reg;
        res_valid    = 1'b0;
        res          = '0;

        unique case (phase_reg)
            dsr_pkg::PH_WAIT: begin
                if (evt.cmd == dsr_pkg::CMD_TICK) begin
                    if (elapsed_reg != '1) begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end else if (evt.cmd == dsr_pkg::CMD_POLL) begin
                    if (evt.data_byte[0]) begin
                        phase_next = dsr_pkg::PH_SCRATCH;
                        count_next = '0;
                        crc_next   = '0;
                    end else if (elapsed_reg > {1'b0, timeout_ms}) begin
                        phase_next      = dsr_pkg::PH_ROM;
                        count_next      = '0;
                        crc_next        = '0;
                        res_valid       = 1'b1;
                        res.status      = dsr_pkg::ST_TIMEOUT;
                        res.sensor_is_s = fam_s_reg;
                    end
                end
            end

            dsr_pkg::PH_SCRATCH: begin
                if (evt.cmd == dsr_pkg::CMD_SCRATCH) begin
                    if (count_reg > dsr_pkg::SCRATCH_LAST) begin
                        cnt = '0;
                    end
                    case (cnt)
                        4'd0:    sp0_next = evt.data_byte;
                        4'd1:    sp1_next = evt.data_byte;
                        4'd4:    sp4_next = evt.data_byte;
                        4'd6:    sp6_next = evt.data_byte;
                        4'd7:    sp7_next = evt.data_byte;
                        default: ;
                    endcase
                    if (cnt < dsr_pkg::SCRATCH_LAST) begin
                        crc_next   = crc_step;
                        count_next = cnt + 1'b1;
                    end else begin
                        phase_next         = dsr_pkg::PH_ROM;
                        count_next         = '0;
                        crc_next           = '0;
                        res_valid          = 1'b1;
                        res.status         = dsr_pkg::ST_TEMP_READY;
                        res.temperature    = temp_val;
                        res.sensor_is_s    = fam_s_reg;
                        res.scratch_crc_ok = (crc_reg == evt.data_byte);
                    end
                end
            end

            default: begin
                // ROM phase, and the unreachable fourth code
                phase_next = dsr_pkg::PH_ROM;
                if (evt.cmd == dsr_pkg::CMD_ROM) begin
                    if (count_reg > dsr_pkg::ROM_LAST) begin
                        cnt = '0;
                    end
                    if (cnt < dsr_pkg::ROM_LAST) begin
                        if (cnt == '0) begin
                            sp0_next = evt.data_byte;
                        end
                        crc_next   = crc_step;
                        count_next = cnt + 1'b1;
                    end else if (crc_reg != evt.data_byte) begin
                        count_next = '0;
                        crc_next   = '0;
                        res_valid  = 1'b1;
                        res.status = dsr_pkg::ST_ROM_CRC_BAD;
                    end else if (sp0_reg == dsr_pkg::FAM_S_PART
                              || sp0_reg == dsr_pkg::FAM_B_PART
                              || sp0_reg == dsr_pkg::FAM_B2_PART) begin
                        fam_s_next      = (sp0_reg == dsr_pkg::FAM_S_PART);
                        phase_next      = dsr_pkg::PH_WAIT;
                        count_next      = '0;
                        crc_next        = '0;
                        elapsed_next    = '0;
                        res_valid       = 1'b1;
                        res.status      = dsr_pkg::ST_CONV_STARTED;
                        res.sensor_is_s = (sp0_reg == dsr_pkg::FAM_S_PART);
                    end else begin
                        count_next = '0;
                        crc_next   = '0;
                        res_valid  = 1'b1;
                        res.status = dsr_pkg::ST_UNKNOWN_FAM;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= dsr_pkg::PH_ROM;
            count_reg   <= '0;
            crc_reg     <= '0;
            fam_s_reg   <= 1'b0;
            elapsed_reg <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            fam_s_reg   <= fam_s_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sp0_reg <= sp0_next;
            sp1_reg <= sp1_next;
            sp4_reg <= sp4_next;
            sp6_reg <= sp6_next;
            sp7_reg <= sp7_next;
        end
    end

endmodule

### rtl/core/ds18x20_readout_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds18x20_readout_sequencer
// Host-side event sequencer for a one-wire temperature sensor readout.
// ----------------------------------------------------------------------------
// Takes one event per cycle (ROM byte, ready poll, scratchpad byte, millisecond
// tick) and gives at most one status transfer per event. Every event passes an
// input register and the single-pass sequencer logic (CRC-8 byte step and the
// temperature conversion) before its result lands in the output register; the
// sustained rate is one event per clock while the sink takes results. The input
// side stalls only while the input register is full and the output register
// holds a result that the sink has not taken.
// The timeout register is written through cfg_*; write it only while idle.
// Events that do not fit the current phase are dropped with no result.
// ----------------------------------------------------------------------------
module ds18x20_readout_sequencer (
    input  logic        aclk,
    input  logic        aresetn,

    // Event stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd

    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] temperature, [16] sensor_is_s,
                                        // [17] scratch_crc_ok, [23:18] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] status

    // Timeout register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic             in_valid_reg;
    dsr_pkg::event_t  in_evt_reg;
    logic             out_valid_reg;
    dsr_pkg::result_t out_res_reg;
    logic [15:0]      timeout_reg;

    logic             advance;
    logic             res_valid;
    dsr_pkg::result_t res;

    // Advance the held event when the output register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= dsr_pkg::TIMEOUT_RESET;
        end else if (cfg_valid) begin
            timeout_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_evt_reg.cmd       <= s_axis_tuser;
            in_evt_reg.data_byte <= s_axis_tdata;
        end
    end

    dsr_seq_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .evt        (in_evt_reg),
        .timeout_ms (timeout_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Output register: load a fresh result, otherwise drop it once transferred
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {6'b000000, out_res_reg.scratch_crc_ok,
                            out_res_reg.sensor_is_s, out_res_reg.temperature};

`ifndef SYNTHESIS
    // Only a temperature result carries temperature and CRC flag
    a_non_temp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != dsr_pkg::ST_TEMP_READY)
        |-> (m_axis_tdata[15:0] == 16'h0000 && !m_axis_tdata[17]))
        else $error("non-temperature result carries payload");

    // ROM failures never flag an S part
    a_rom_fail_no_s: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == dsr_pkg::ST_ROM_CRC_BAD
                        || m_axis_tuser == dsr_pkg::ST_UNKNOWN_FAM))
        |-> !m_axis_tdata[16])
        else $error("ROM failure reports sensor_is_s");

    // A full input register behind a stalled result must hold off the source
    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while pipeline is blocked");

    // Status codes beyond temperature ready are never produced
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser <= dsr_pkg::ST_TEMP_READY))
        else $error("status code out of range");
`endif

endmodule
